>>> design/gha_pkg.sv
// Shared types, field widths and codes of the generational handle allocator.
`default_nettype none

package gha_pkg;

   localparam int MAX_SLOTS_DEF   = 1024;
   localparam int GEN_BITS_DEF    = 16;
   localparam int DEFER_DEPTH_DEF = 1024;

   localparam int MODE_W   = 3;
   localparam int ID_W     = 10;
   localparam int GEN_IN_W = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE  = 3'd0,
      MODE_DESTROY = 3'd1,
      MODE_CHECK   = 3'd2,
      MODE_DEFER   = 3'd3,
      MODE_FLUSH   = 3'd4,
      MODE_CLEAR   = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_INVALID    = 2'd1,
      ST_NO_SLOT    = 2'd2,
      ST_QUEUE_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_GEN,
      S_FLUSH_Q,
      S_FLUSH_G,
      S_CLEAR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      status_type          status;
      logic [GEN_IN_W-1:0] generation;
      logic [ID_W-1:0]     id;
   } result_type;

endpackage

`default_nettype wire

>>> design/generational_handle_allocator.sv
// Top level of the generational handle allocator: sequencer around three table RAMs.
//
//   channel | dir | beat contents
//   req_    | in  | tuser: mode; tdata: handle_id, handle_generation
//   rsp_    | out | tdata: out_id, out_generation, status, destroyed_count
//
// Create, destroy, check and defer read the generation table, then act on the entry (create
// from the free stack: stack read, then generation table read, then write back).
// Flush reads each queued entry in turn: queue read, then table read-modify-write.
// Clear does one table read-modify-write per slot used so far.
// No clearing pass after reset: table entries at or above high_water read as zero.
// A result waits in the output register; one more is parked while the sequencer stalls.
`default_nettype none

module generational_handle_allocator #(
   parameter int MAX_SLOTS   = gha_pkg::MAX_SLOTS_DEF,
   parameter int GEN_BITS    = gha_pkg::GEN_BITS_DEF,
   parameter int DEFER_DEPTH = gha_pkg::DEFER_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [9:0] handle_id, [25:10] handle_generation, [31:26] zero
   input  wire logic [gha_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] mode
   input  wire logic [gha_pkg::MODE_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [9:0] out_id, [25:10] out_generation, [27:26] status,
   // [38:28] destroyed_count, [39] zero
   output logic      [gha_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int SLOT_W  = $clog2(MAX_SLOTS);
   localparam int SCNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int DADDR_W = (DEFER_DEPTH > 1) ? $clog2(DEFER_DEPTH) : 1;
   localparam int DCNT_W  = $clog2(DEFER_DEPTH + 1);
   localparam int ENT_W   = GEN_BITS + 1;
   localparam int QENT_W  = gha_pkg::ID_W + gha_pkg::GEN_IN_W;
   localparam int CMP_W   = (GEN_BITS > gha_pkg::GEN_IN_W) ? GEN_BITS : gha_pkg::GEN_IN_W;

   gha_pkg::state_type  state_ff, state_in;
   gha_pkg::mode_type   mode_ff, mode_in;
   logic [gha_pkg::ID_W-1:0]     hid_ff, hid_in;
   logic [gha_pkg::GEN_IN_W-1:0] hgen_ff, hgen_in;
   logic                         id_ok_ff, id_ok_in;
   logic                         rd_zero_ff, rd_zero_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [SCNT_W-1:0]            free_count_ff, free_count_in;
   logic [SCNT_W-1:0]            next_fresh_ff, next_fresh_in;
   logic [SCNT_W-1:0]            high_water_ff, high_water_in;
   logic [SCNT_W-1:0]            cidx_ff, cidx_in;
   logic [DCNT_W-1:0]            defer_count_ff, defer_count_in;
   logic [DCNT_W-1:0]            qidx_ff, qidx_in;
   logic [gha_pkg::COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                         rsp_valid_ff;
   gha_pkg::result_type          rsp_ff, pend_ff, res;
   logic                         finish;
   logic                         accept;
   logic                         out_free;

   logic                gen_wr_en, gen_rd_en;
   logic [SLOT_W-1:0]   gen_wr_addr, gen_rd_addr;
   logic [ENT_W-1:0]    gen_wr_data, gen_rd_data, gen_data;
   logic                stk_wr_en, stk_rd_en;
   logic [SLOT_W-1:0]   stk_wr_addr, stk_rd_addr, stk_wr_data, stk_rd_data;
   logic                que_wr_en, que_rd_en;
   logic [DADDR_W-1:0]  que_wr_addr, que_rd_addr;
   logic [QENT_W-1:0]   que_wr_data, que_rd_data;

   logic [GEN_BITS-1:0] gval, gbump;
   logic                live, valid;

   function automatic logic id_check(input logic [gha_pkg::ID_W-1:0] id,
                                     input logic [SCNT_W-1:0] hw);
      return (id != '0) && (32'(id) < 32'(MAX_SLOTS)) && (32'(id) < 32'(hw));
   endfunction

   gha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SLOTS)) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (gen_wr_addr),
      .wr_data (gen_wr_data),
      .rd_en   (gen_rd_en),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data)
   );

   gha_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   gha_ram #(.WIDTH(QENT_W), .DEPTH(DEFER_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (que_wr_en),
      .wr_addr (que_wr_addr),
      .wr_data (que_wr_data),
      .rd_en   (que_rd_en),
      .rd_addr (que_rd_addr),
      .rd_data (que_rd_data)
   );

   assign req_tready = (state_ff == gha_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign gen_data = rd_zero_ff ? '0 : gen_rd_data;
   assign live     = gen_data[GEN_BITS];
   assign gval     = gen_data[GEN_BITS-1:0];
   assign gbump    = gval + GEN_BITS'(1);
   assign valid    = id_ok_ff && live && (CMP_W'(gval) == CMP_W'(hgen_ff));

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      hid_in         = hid_ff;
      hgen_in        = hgen_ff;
      id_ok_in       = id_ok_ff;
      rd_zero_in     = rd_zero_ff;
      slot_in        = slot_ff;
      free_count_in  = free_count_ff;
      next_fresh_in  = next_fresh_ff;
      high_water_in  = high_water_ff;
      cidx_in        = cidx_ff;
      defer_count_in = defer_count_ff;
      qidx_in        = qidx_ff;
      cnt_in         = cnt_ff;
      finish         = 1'b0;
      res            = '0;
      res.status     = gha_pkg::ST_OK;
      gen_wr_en      = 1'b0;
      gen_wr_addr    = slot_ff;
      gen_wr_data    = '0;
      gen_rd_en      = 1'b0;
      gen_rd_addr    = '0;
      stk_wr_en      = 1'b0;
      stk_wr_addr    = SLOT_W'(free_count_ff);
      stk_wr_data    = slot_ff;
      stk_rd_en      = 1'b0;
      stk_rd_addr    = '0;
      que_wr_en      = 1'b0;
      que_wr_addr    = DADDR_W'(defer_count_ff);
      que_wr_data    = {hgen_ff, hid_ff};
      que_rd_en      = 1'b0;
      que_rd_addr    = '0;

      case (state_ff)
         gha_pkg::S_IDLE: begin
            if (accept) begin
               mode_in    = gha_pkg::mode_type'(req_tuser);
               hid_in     = req_tdata[gha_pkg::ID_W-1:0];
               hgen_in    = req_tdata[QENT_W-1:gha_pkg::ID_W];
               id_ok_in   = id_check(req_tdata[gha_pkg::ID_W-1:0], high_water_ff);
               rd_zero_in = 1'b0;
               case (gha_pkg::mode_type'(req_tuser))
                  gha_pkg::MODE_CREATE: begin
                     if (free_count_ff != '0) begin
                        stk_rd_en     = 1'b1;
                        stk_rd_addr   = SLOT_W'(free_count_ff - SCNT_W'(1));
                        free_count_in = free_count_ff - SCNT_W'(1);
                        state_in      = gha_pkg::S_POP;
                     end else if (next_fresh_ff < SCNT_W'(MAX_SLOTS)) begin
                        slot_in       = SLOT_W'(next_fresh_ff);
                        gen_rd_en     = 1'b1;
                        gen_rd_addr   = SLOT_W'(next_fresh_ff);
                        rd_zero_in    = (next_fresh_ff >= high_water_ff);
                        next_fresh_in = next_fresh_ff + SCNT_W'(1);
                        if (high_water_ff < next_fresh_ff + SCNT_W'(1)) begin
                           high_water_in = next_fresh_ff + SCNT_W'(1);
                        end
                        state_in = gha_pkg::S_GEN;
                     end else begin
                        finish     = 1'b1;
                        res.status = gha_pkg::ST_NO_SLOT;
                     end
                  end
                  gha_pkg::MODE_DESTROY, gha_pkg::MODE_CHECK, gha_pkg::MODE_DEFER: begin
                     slot_in     = SLOT_W'(req_tdata[gha_pkg::ID_W-1:0]);
                     gen_rd_en   = 1'b1;
                     gen_rd_addr = SLOT_W'(req_tdata[gha_pkg::ID_W-1:0]);
                     state_in    = gha_pkg::S_GEN;
                  end
                  gha_pkg::MODE_FLUSH: begin
                     cnt_in  = '0;
                     qidx_in = '0;
                     if (defer_count_ff == '0) begin
                        finish = 1'b1;
                     end else begin
                        que_rd_en   = 1'b1;
                        que_rd_addr = '0;
                        state_in    = gha_pkg::S_FLUSH_Q;
                     end
                  end
                  gha_pkg::MODE_CLEAR: begin
                     next_fresh_in  = SCNT_W'(1);
                     free_count_in  = '0;
                     defer_count_in = '0;
                     if (high_water_ff > SCNT_W'(1)) begin
                        cidx_in     = SCNT_W'(1);
                        gen_rd_en   = 1'b1;
                        gen_rd_addr = SLOT_W'(1);
                        state_in    = gha_pkg::S_CLEAR;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         gha_pkg::S_POP: begin
            slot_in     = stk_rd_data;
            gen_rd_en   = 1'b1;
            gen_rd_addr = stk_rd_data;
            rd_zero_in  = (SCNT_W'(stk_rd_data) >= high_water_ff);
            state_in    = gha_pkg::S_GEN;
         end
         gha_pkg::S_GEN: begin
            finish = 1'b1;
            case (mode_ff)
               gha_pkg::MODE_CREATE: begin
                  gen_wr_en      = 1'b1;
                  gen_wr_data    = {1'b1, gval};
                  res.id         = gha_pkg::ID_W'(slot_ff);
                  res.generation = gha_pkg::GEN_IN_W'(gval);
               end
               gha_pkg::MODE_DESTROY: begin
                  if (valid) begin
                     gen_wr_en   = 1'b1;
                     gen_wr_data = {1'b0, gbump};
                     if (free_count_ff < SCNT_W'(MAX_SLOTS)) begin
                        stk_wr_en     = 1'b1;
                        free_count_in = free_count_ff + SCNT_W'(1);
                     end
                  end else begin
                     res.status = gha_pkg::ST_INVALID;
                  end
               end
               gha_pkg::MODE_CHECK: begin
                  if (!valid) begin
                     res.status = gha_pkg::ST_INVALID;
                  end
               end
               gha_pkg::MODE_DEFER: begin
                  if (!valid) begin
                     res.status = gha_pkg::ST_INVALID;
                  end else if (defer_count_ff >= DCNT_W'(DEFER_DEPTH)) begin
                     res.status = gha_pkg::ST_QUEUE_FULL;
                  end else begin
                     que_wr_en      = 1'b1;
                     defer_count_in = defer_count_ff + DCNT_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         gha_pkg::S_FLUSH_Q: begin
            hid_in      = que_rd_data[gha_pkg::ID_W-1:0];
            hgen_in     = que_rd_data[QENT_W-1:gha_pkg::ID_W];
            id_ok_in    = id_check(que_rd_data[gha_pkg::ID_W-1:0], high_water_ff);
            slot_in     = SLOT_W'(que_rd_data[gha_pkg::ID_W-1:0]);
            gen_rd_en   = 1'b1;
            gen_rd_addr = SLOT_W'(que_rd_data[gha_pkg::ID_W-1:0]);
            rd_zero_in  = 1'b0;
            state_in    = gha_pkg::S_FLUSH_G;
         end
         gha_pkg::S_FLUSH_G: begin
            if (valid) begin
               gen_wr_en   = 1'b1;
               gen_wr_data = {1'b0, gbump};
               cnt_in      = cnt_ff + gha_pkg::COUNT_W'(1);
               if (free_count_ff < SCNT_W'(MAX_SLOTS)) begin
                  stk_wr_en     = 1'b1;
                  free_count_in = free_count_ff + SCNT_W'(1);
               end
            end
            if (qidx_ff + DCNT_W'(1) < defer_count_ff) begin
               qidx_in     = qidx_ff + DCNT_W'(1);
               que_rd_en   = 1'b1;
               que_rd_addr = DADDR_W'(qidx_ff + DCNT_W'(1));
               state_in    = gha_pkg::S_FLUSH_Q;
            end else begin
               finish         = 1'b1;
               res.count      = cnt_in;
               defer_count_in = '0;
            end
         end
         gha_pkg::S_CLEAR: begin
            gen_wr_en   = 1'b1;
            gen_wr_addr = SLOT_W'(cidx_ff);
            gen_wr_data = {1'b0, gbump};
            if (cidx_ff + SCNT_W'(1) < high_water_ff) begin
               cidx_in     = cidx_ff + SCNT_W'(1);
               gen_rd_en   = 1'b1;
               gen_rd_addr = SLOT_W'(cidx_ff + SCNT_W'(1));
            end else begin
               finish = 1'b1;
            end
         end
         gha_pkg::S_RESP: begin
            if (out_free) begin
               state_in = gha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gha_pkg::S_IDLE;
         end
      endcase

      if (finish) begin
         state_in = out_free ? gha_pkg::S_IDLE : gha_pkg::S_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gha_pkg::S_IDLE;
         free_count_ff  <= '0;
         next_fresh_ff  <= SCNT_W'(1);
         high_water_ff  <= SCNT_W'(1);
         defer_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_count_ff  <= free_count_in;
         next_fresh_ff  <= next_fresh_in;
         high_water_ff  <= high_water_in;
         defer_count_ff <= defer_count_in;
         if ((finish || state_ff == gha_pkg::S_RESP) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      hid_ff     <= hid_in;
      hgen_ff    <= hgen_in;
      id_ok_ff   <= id_ok_in;
      rd_zero_ff <= rd_zero_in;
      slot_ff    <= slot_in;
      cidx_ff    <= cidx_in;
      qidx_ff    <= qidx_in;
      cnt_ff     <= cnt_in;
      if (finish) begin
         if (out_free) begin
            rsp_ff <= res;
         end else begin
            pend_ff <= res;
         end
      end else if (state_ff == gha_pkg::S_RESP && out_free) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   a_free_bound : assert property (@(posedge clock) disable iff (reset)
      free_count_ff < SCNT_W'(MAX_SLOTS))
      else $error("free stack count exceeds slot count");

   a_fresh_order : assert property (@(posedge clock) disable iff (reset)
      (next_fresh_ff <= high_water_ff) && (high_water_ff != '0)
      && (high_water_ff <= SCNT_W'(MAX_SLOTS)))
      else $error("fresh slot pointer beyond high water mark");

   a_defer_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gha_pkg::S_FLUSH_G) |-> (qidx_ff < defer_count_ff))
      else $error("flush walk beyond queued entries");

   a_park_stall : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gha_pkg::S_RESP) |-> rsp_valid_ff)
      else $error("parked result without a waiting output beat");

endmodule

`default_nettype wire

>>> design/gha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> verif/generational_handle_allocator_test.sv
// Self-checking testbench for the generational handle allocator stream interface.
`default_nettype none

module generational_handle_allocator_test;

   localparam int MODE_W     = gha_pkg::MODE_W;
   localparam int ID_W       = gha_pkg::ID_W;
   localparam int GEN_IN_W   = gha_pkg::GEN_IN_W;
   localparam int COUNT_W    = gha_pkg::COUNT_W;
   localparam int REQ_DATA_W = gha_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = gha_pkg::RSP_DATA_W;
   localparam int SLOT_COUNT  = gha_pkg::MAX_SLOTS_DEF;
   localparam int QUEUE_DEPTH = gha_pkg::DEFER_DEPTH_DEF;
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int RESULT_W = $bits(gha_pkg::result_type);

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // allocator image kept alongside the block
   bit [GEN_IN_W-1:0] gen_table [SLOT_COUNT];
   bit live [SLOT_COUNT];
   bit [ID_W-1:0] free_stack [SLOT_COUNT];
   bit [ID_W-1:0] defer_id [QUEUE_DEPTH];
   bit [GEN_IN_W-1:0] defer_gen [QUEUE_DEPTH];
   int free_count = 0;
   int next_fresh = 1;
   int high_water = 1;
   int defer_count = 0;
   int live_slots [$];

   gha_pkg::result_type expected_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int item_count = 0;
   int result_count = 0;
   int no_slot_count = 0;
   int queue_full_count = 0;
   int flushed_total = 0;
   int clear_count = 0;

   generational_handle_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit handle_live(int id, bit [GEN_IN_W-1:0] gen);
      return id != 0 && id < SLOT_COUNT && id < high_water && live[id] && gen_table[id] == gen;
   endfunction

   function automatic void release_slot(int slot);
      int hits [$];
      live[slot] = 1'b0;
      gen_table[slot] = gen_table[slot] + 1'b1;
      if (free_count < SLOT_COUNT) begin
         free_stack[free_count] = ID_W'(slot);
         free_count++;
      end
      hits = live_slots.find_first_index(x) with (x == slot);
      if (hits.size() != 0) live_slots.delete(hits[0]);
   endfunction

   function automatic gha_pkg::result_type predict_allocator(logic [MODE_W-1:0] mode,
                                                             logic [ID_W-1:0] id,
                                                             logic [GEN_IN_W-1:0] gen);
      gha_pkg::result_type res;
      int slot;
      int destroyed;
      res = '0;
      case (mode)
         gha_pkg::MODE_CREATE: begin
            slot = -1;
            if (free_count > 0) begin
               free_count--;
               slot = free_stack[free_count];
            end else if (next_fresh < SLOT_COUNT) begin
               slot = next_fresh;
               next_fresh++;
               if (high_water < slot + 1) high_water = slot + 1;
            end
            if (slot < 0) begin
               res.status = gha_pkg::ST_NO_SLOT;
               no_slot_count++;
            end else begin
               live[slot] = 1'b1;
               live_slots = {live_slots, slot};
               res.id = ID_W'(slot);
               res.generation = gen_table[slot];
            end
         end
         gha_pkg::MODE_DESTROY: begin
            if (handle_live(id, gen)) release_slot(id);
            else res.status = gha_pkg::ST_INVALID;
         end
         gha_pkg::MODE_CHECK: begin
            if (!handle_live(id, gen)) res.status = gha_pkg::ST_INVALID;
         end
         gha_pkg::MODE_DEFER: begin
            if (!handle_live(id, gen)) begin
               res.status = gha_pkg::ST_INVALID;
            end else if (defer_count >= QUEUE_DEPTH) begin
               res.status = gha_pkg::ST_QUEUE_FULL;
               queue_full_count++;
            end else begin
               defer_id[defer_count] = id;
               defer_gen[defer_count] = gen;
               defer_count++;
            end
         end
         gha_pkg::MODE_FLUSH: begin
            destroyed = 0;
            for (int i = 0; i < defer_count; i++) begin
               if (handle_live(defer_id[i], defer_gen[i])) begin
                  release_slot(defer_id[i]);
                  destroyed++;
               end
            end
            defer_count = 0;
            flushed_total += destroyed;
            res.count = COUNT_W'(destroyed);
         end
         gha_pkg::MODE_CLEAR: begin
            for (int i = 1; i < high_water; i++) begin
               gen_table[i] = gen_table[i] + 1'b1;
               live[i] = 1'b0;
            end
            next_fresh = 1;
            free_count = 0;
            defer_count = 0;
            live_slots.delete();
            clear_count++;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                               input logic [GEN_IN_W-1:0] gen);
      gha_pkg::result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {{(REQ_DATA_W - ID_W - GEN_IN_W){1'b0}}, gen, id};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      want = predict_allocator(mode, id, gen);
      expected_results = {expected_results, want};
      item_count++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      error_count++;
      $display("mismatch at response beat %0d: %s expected %0d got %0d",
               result_count, what, want, got);
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      gha_pkg::result_type got;
      gha_pkg::result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_tdata[RESULT_W-1:0];
         result_count++;
         if (expected_results.size() == 0) begin
            report_mismatch("beat with nothing pending, id", 0, got.id);
         end else begin
            want = expected_results.pop_front();
            if (got.id !== want.id) report_mismatch("out_id", want.id, got.id);
            if (got.generation !== want.generation)
               report_mismatch("out_generation", want.generation, got.generation);
            if (got.status !== want.status) report_mismatch("status", want.status, got.status);
            if (got.count !== want.count)
               report_mismatch("destroyed_count", want.count, got.count);
         end
      end
   end

   function automatic bit pick_live(output logic [ID_W-1:0] id, output logic [GEN_IN_W-1:0] gen);
      int slot;
      if (live_slots.size() == 0) return 1'b0;
      slot = live_slots[$urandom_range(live_slots.size() - 1)];
      id = ID_W'(slot);
      gen = gen_table[slot];
      return 1'b1;
   endfunction

   task automatic test_create_and_check();
      send_request(gha_pkg::MODE_CREATE, '0, '0);
      send_request(gha_pkg::MODE_CREATE, '1, '1);
      send_request(gha_pkg::MODE_CHECK, 10'd1, 16'd0);
   endtask

   task automatic test_invalid_handles();
      send_request(gha_pkg::MODE_CHECK, 10'd0, 16'd0);
      send_request(gha_pkg::MODE_CHECK, 10'd1023, 16'hFFFF);
      send_request(gha_pkg::MODE_DESTROY, 10'd1, 16'hFFFF);
      send_request(gha_pkg::MODE_DEFER, 10'd0, 16'd0);
      send_request(gha_pkg::MODE_CHECK, 10'd3, 16'd0);
   endtask

   task automatic test_destroy_and_reuse();
      send_request(gha_pkg::MODE_DESTROY, 10'd1, 16'd0);
      send_request(gha_pkg::MODE_DESTROY, 10'd1, 16'd0);
      send_request(gha_pkg::MODE_CHECK, 10'd1, 16'd1);
      send_request(gha_pkg::MODE_CREATE, '0, '0);
   endtask

   task automatic test_deferred_destroy();
      send_request(gha_pkg::MODE_DEFER, 10'd2, 16'd0);
      send_request(gha_pkg::MODE_DEFER, 10'd2, 16'd0);
      send_request(gha_pkg::MODE_FLUSH, '0, '0);
      send_request(gha_pkg::MODE_FLUSH, '1, '1);
      send_request(gha_pkg::MODE_CHECK, 10'd2, 16'd0);
   endtask

   task automatic test_undefined_modes();
      send_request(MODE_SPARE_LO, 10'd1023, 16'hFFFF);
      send_request(MODE_SPARE_HI, 10'd1, 16'd1);
   endtask

   task automatic test_clear_all();
      send_request(gha_pkg::MODE_CLEAR, '0, '0);
      send_request(gha_pkg::MODE_CHECK, 10'd1, 16'd1);
      send_request(gha_pkg::MODE_CREATE, '0, '0);
      send_request(gha_pkg::MODE_CREATE, '0, '0);
   endtask

   task automatic test_slot_exhaustion();
      send_request(gha_pkg::MODE_CLEAR, '0, '0);
      while (free_count > 0 || next_fresh < SLOT_COUNT)
         send_request(gha_pkg::MODE_CREATE, ID_W'($urandom), GEN_IN_W'($urandom));
      send_request(gha_pkg::MODE_CREATE, '0, '0);
   endtask

   task automatic test_queue_overflow();
      logic [ID_W-1:0] id;
      logic [GEN_IN_W-1:0] gen;
      repeat (QUEUE_DEPTH + 1) begin
         if (pick_live(id, gen)) send_request(gha_pkg::MODE_DEFER, id, gen);
      end
      send_request(gha_pkg::MODE_FLUSH, '0, '0);
      repeat (8) send_request(gha_pkg::MODE_CREATE, '0, '0);
      send_request(gha_pkg::MODE_CLEAR, '0, '0);
   endtask

   task automatic test_random_traffic(input int beats);
      logic [ID_W-1:0] id;
      logic [GEN_IN_W-1:0] gen;
      logic [MODE_W-1:0] mode;
      int pick;
      repeat (beats) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_request(gha_pkg::MODE_CREATE, ID_W'($urandom), GEN_IN_W'($urandom));
         end else if (pick < 72 && pick_live(id, gen)) begin
            if (pick < 45) mode = gha_pkg::MODE_DESTROY;
            else if (pick < 55) mode = gha_pkg::MODE_CHECK;
            else mode = gha_pkg::MODE_DEFER;
            send_request(mode, id, gen);
         end else if (pick < 78) begin
            send_request(gha_pkg::MODE_FLUSH, ID_W'($urandom), GEN_IN_W'($urandom));
         end else if (pick < 80) begin
            send_request(gha_pkg::MODE_CLEAR, ID_W'($urandom), GEN_IN_W'($urandom));
         end else if (pick < 90) begin
            id = ID_W'($urandom_range(high_water - 1));
            gen = GEN_IN_W'(gen_table[id] - $urandom_range(1));
            mode = MODE_W'($urandom_range(gha_pkg::MODE_DESTROY, gha_pkg::MODE_DEFER));
            send_request(mode, id, gen);
         end else begin
            send_request(MODE_W'($urandom), ID_W'($urandom), GEN_IN_W'($urandom));
         end
      end
   endtask

   initial begin
      send_idle_pct = 14;
      recv_idle_pct = 86;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_create_and_check();
      test_invalid_handles();
      test_destroy_and_reuse();
      test_deferred_destroy();
      test_undefined_modes();
      test_clear_all();
      test_slot_exhaustion();

      send_idle_pct = 86;
      recv_idle_pct = 14;
      test_queue_overflow();
      test_random_traffic(150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(200);

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("beats still pending", 0, expected_results.size());

      $display("Sent %0d request beats and checked %0d response beats over all modes.",
               item_count, result_count);
      $display("Slots ran out %0d times, queue overflowed %0d times, %0d flushed, %0d clears.",
               no_slot_count, queue_full_count, flushed_total, clear_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
design/gha_pkg.sv
design/gha_ram.sv
design/generational_handle_allocator.sv
verif/generational_handle_allocator_test.sv
